// File: hw/rtl/signed_graph_norm_update_macros.svh
// assertion macros shared by the rtl
// each macro takes a label, a clock, an active-low reset and two expressions
`ifndef SIGNED_GRAPH_NORM_UPDATE_MACROS_SVH
`define SIGNED_GRAPH_NORM_UPDATE_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define SGNU_ASSERT_IMPL(lbl, ck, rn, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (pre) |-> (post)) \
    else $error("assertion failed: lbl");
// next-cycle implication
`define SGNU_ASSERT_NEXT(lbl, ck, rn, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (pre) |=> (post)) \
    else $error("assertion failed: lbl");
`else
`define SGNU_ASSERT_IMPL(lbl, ck, rn, pre, post)
`define SGNU_ASSERT_NEXT(lbl, ck, rn, pre, post)
`endif

`endif

// File: hw/rtl/sgnu_pkg.sv
`timescale 1ns / 1ps

package sgnu_pkg;

  // fixed field widths
  localparam int STATE_W   = 36;
  localparam int IDX_W     = 3;
  localparam int RULE_W    = 2;
  localparam int NODES_DEF = 6;

  // norm rule codes
  typedef enum logic [RULE_W-1:0] {
    RULE_L4 = 2'd0,
    RULE_L6 = 2'd1,
    RULE_L7 = 2'd2,
    RULE_L8 = 2'd3
  } rule_t;

  // new opinion from a = own view of actor, b = actor on target, c = own view of target
  function automatic logic apply_rule(input rule_t r, input logic a, input logic b,
                                      input logic c);
    logic res;
    case (r)
      RULE_L4: res = b ? (a | c) : ~c;
      RULE_L6: res = ~(b ^ c);
      RULE_L7: res = b ? (a | c) : (a & ~c);
      RULE_L8: res = b ? c : (a & ~c);
      default: res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

// File: hw/rtl/sgnu_in_if.sv
`timescale 1ns / 1ps

interface sgnu_in_if;
  logic                         valid;
  logic                         ready;
  logic [sgnu_pkg::STATE_W-1:0] current_state;
  logic [sgnu_pkg::IDX_W-1:0]   actor_node;
  logic [sgnu_pkg::IDX_W-1:0]   target_node;

  modport source (output valid, output current_state, output actor_node,
                  output target_node, input ready);
  modport sink (input valid, input current_state, input actor_node,
                input target_node, output ready);
endinterface

// File: hw/rtl/sgnu_out_if.sv
`timescale 1ns / 1ps

interface sgnu_out_if;
  logic                         valid;
  logic                         ready;
  logic [sgnu_pkg::STATE_W-1:0] next_state;

  modport source (output valid, output next_state, input ready);
  modport sink (input valid, input next_state, output ready);
endinterface

// File: hw/rtl/sgnu_rule_col.sv
`timescale 1ns / 1ps

module sgnu_rule_col #(
  parameter int NODES = sgnu_pkg::NODES_DEF
) (
  input  sgnu_pkg::rule_t             rule,
  input  logic [NODES-1:0]            col_a,
  input  logic [NODES-1:0]            col_c,
  input  logic                        b,
  input  logic                        diag,
  input  logic [$clog2(NODES)-1:0]    x,
  output logic [NODES-1:0]            new_col
);

  localparam int XW = $clog2(NODES);

  // when actor equals target, rows past the actor see the already updated diagonal
  logic b_diag;
  assign b_diag = sgnu_pkg::apply_rule(rule, b, b, b);

  // one rule cell per observer row
  for (genvar l = 0; l < NODES; l++) begin : g_row
    logic b_eff;
    assign b_eff      = (diag && (x < XW'(l))) ? b_diag : b;
    assign new_col[l] = sgnu_pkg::apply_rule(rule, col_a[l], b_eff, col_c[l]);
  end

endmodule

// File: hw/rtl/signed_graph_norm_update.sv
`timescale 1ns / 1ps
// signed graph norm update
// in_ch carries a packed sign matrix (bit i*NODES+j set = +1) with an actor and a
// target node; out_ch returns the matrix after every observer row has rewritten
// its opinion of the actor under the norm rule held in the rule register.
// cfg_we / cfg_wdata write the rule register (0 L4, 1 L6, 2 L7, 3 L8); write it
// only while no item is in flight.
// three register stages (column extract, rule cells, column merge into the
// output); an accepted item moves through the stage a, b and c registers in turn,
// and out_ch.valid is the stage c valid bit.
// throughput: one item per cycle while out_ch.ready is high; every stage holds its own valid bit and ready
// so bubbles close up under a stall.
// a stalled receiver holds the output register; upstream stages keep filling
// until all three are full, then in_ch.ready drops. nothing is dropped or
// repeated.
// a node index of NODES or above passes the matrix through unchanged; bits
// above the matrix are ignored and return as zero.
// reset (synchronous, rst_n low) empties the pipeline and sets the rule to L8.

`include "signed_graph_norm_update_macros.svh"

module signed_graph_norm_update #(
  parameter int NODES = sgnu_pkg::NODES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  sgnu_in_if.sink                     in_ch,
  sgnu_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [sgnu_pkg::RULE_W-1:0] cfg_wdata
);

  localparam int MW = NODES * NODES;
  localparam int XW = $clog2(NODES);
  localparam int SW = sgnu_pkg::STATE_W;
  localparam int IW = sgnu_pkg::IDX_W;

  // rule register
  sgnu_pkg::rule_t rule_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_r <= sgnu_pkg::RULE_L8;
    end else if (cfg_we) begin
      rule_r <= sgnu_pkg::rule_t'(cfg_wdata);
    end
  end

  // per-stage handshake
  logic a_valid_r, b_valid_r, c_valid_r;
  logic rdy_a, rdy_b, rdy_c;
  assign rdy_c       = !c_valid_r || out_ch.ready;
  assign rdy_b       = !b_valid_r || rdy_c;
  assign rdy_a       = !a_valid_r || rdy_b;
  assign in_ch.ready = rdy_a;

  // input matrix, trimmed or zero-filled to NODES*NODES bits
  logic [MW-1:0] in_mat;
  for (genvar k = 0; k < MW; k++) begin : g_in
    if (k < SW) begin : g_bit
      assign in_mat[k] = in_ch.current_state[k];
    end else begin : g_zero
      assign in_mat[k] = 1'b0;
    end
  end

  // stage a: range check and column extract
  logic          in_ok;
  logic [XW-1:0] x_idx, y_idx;
  logic [NODES-1:0] col_a_nxt, col_c_nxt;
  assign in_ok = ({1'b0, in_ch.actor_node} < (IW+1)'(NODES)) &&
                 ({1'b0, in_ch.target_node} < (IW+1)'(NODES));
  assign x_idx = in_ch.actor_node[XW-1:0];
  assign y_idx = in_ch.target_node[XW-1:0];

  for (genvar l = 0; l < NODES; l++) begin : g_col
    logic [NODES-1:0] row;
    assign row          = in_mat[l*NODES +: NODES];
    assign col_a_nxt[l] = in_ok & row[x_idx];
    assign col_c_nxt[l] = in_ok & row[y_idx];
  end

  logic [MW-1:0]    a_mat_r;
  logic [NODES-1:0] a_col_a_r, a_col_c_r;
  logic             a_b_r, a_diag_r, a_ok_r;
  logic [XW-1:0]    a_x_r;

  // stage b: rule cells
  logic [NODES-1:0] new_col;
  logic [MW-1:0]    b_mat_r;
  logic [NODES-1:0] b_col_r;
  logic [XW-1:0]    b_x_r;
  logic             b_ok_r;

  sgnu_rule_col #(.NODES(NODES)) u_rule_col (
    .rule    (rule_r),
    .col_a   (a_col_a_r),
    .col_c   (a_col_c_r),
    .b       (a_b_r),
    .diag    (a_diag_r),
    .x       (a_x_r),
    .new_col (new_col)
  );

  // stage c: merge new column into the matrix
  logic [MW-1:0] merged;
  logic [SW-1:0] state_nxt;
  logic [SW-1:0] c_state_r;
  for (genvar l = 0; l < NODES; l++) begin : g_mr
    for (genvar j = 0; j < NODES; j++) begin : g_mc
      assign merged[l*NODES+j] = (b_ok_r && (b_x_r == XW'(j))) ? b_col_r[l]
                                                              : b_mat_r[l*NODES+j];
    end
  end
  for (genvar k = 0; k < SW; k++) begin : g_out
    if (k < MW) begin : g_bit
      assign state_nxt[k] = merged[k];
    end else begin : g_zero
      assign state_nxt[k] = 1'b0;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      if (rdy_a) a_valid_r <= in_ch.valid;
      if (rdy_b) b_valid_r <= a_valid_r;
      if (rdy_c) c_valid_r <= b_valid_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rdy_a && in_ch.valid) begin
      a_mat_r   <= in_mat;
      a_col_a_r <= col_a_nxt;
      a_col_c_r <= col_c_nxt;
      a_b_r     <= in_ok & col_c_nxt[x_idx];
      a_diag_r  <= (in_ch.actor_node == in_ch.target_node);
      a_x_r     <= x_idx;
      a_ok_r    <= in_ok;
    end
    if (rdy_b && a_valid_r) begin
      b_mat_r <= a_mat_r;
      b_col_r <= new_col;
      b_x_r   <= a_x_r;
      b_ok_r  <= a_ok_r;
    end
    if (rdy_c && b_valid_r) begin
      c_state_r <= state_nxt;
    end
  end

  assign out_ch.valid      = c_valid_r;
  assign out_ch.next_state = c_state_r;

  // checks
  `SGNU_ASSERT_NEXT(a_accept_fills, clk, rst_n, in_ch.valid && in_ch.ready, a_valid_r)
  `SGNU_ASSERT_NEXT(b_to_c_moves, clk, rst_n, b_valid_r && rdy_c, c_valid_r)
  `SGNU_ASSERT_IMPL(stall_only_full, clk, rst_n, !in_ch.ready,
                    a_valid_r && b_valid_r && c_valid_r && !out_ch.ready)

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

// scoreboard: predicts the next sign matrix for each accepted item and
// checks results in order
class norm_scoreboard;
  localparam int N = sgnu_pkg::NODES_DEF;

  logic [sgnu_pkg::STATE_W-1:0] expected_states[$];
  int fail_count = 0;

  // new opinion of observer from own view a, actor-on-target b, own view c
  static function logic next_opinion(sgnu_pkg::rule_t r, logic a, logic b, logic c);
    logic v;
    case (r)
      sgnu_pkg::RULE_L4: begin
        if (b) v = a | c;
        else v = ~c;
      end
      sgnu_pkg::RULE_L6: v = (b == c);
      sgnu_pkg::RULE_L7: begin
        if (b) v = a | c;
        else v = a & ~c;
      end
      default: begin
        if (b) v = c;
        else v = a & ~c;
      end
    endcase
    return v;
  endfunction

  // every observer rewrites its view of the actor, in row order
  static function logic [sgnu_pkg::STATE_W-1:0] predict_next(
      logic [sgnu_pkg::STATE_W-1:0] state, logic [sgnu_pkg::IDX_W-1:0] x,
      logic [sgnu_pkg::IDX_W-1:0] y, sgnu_pkg::rule_t r);
    logic [sgnu_pkg::STATE_W-1:0] m;
    logic a, b, c;
    int xi, yi;
    m = state;
    xi = x;
    yi = y;
    if (xi < N && yi < N) begin
      for (int l = 0; l < N; l++) begin
        a = m[l * N + xi];
        b = m[xi * N + yi];
        c = m[l * N + yi];
        m[l * N + xi] = next_opinion(r, a, b, c);
      end
    end
    return m;
  endfunction

  function void note_item(logic [sgnu_pkg::STATE_W-1:0] state,
                          logic [sgnu_pkg::IDX_W-1:0] x, logic [sgnu_pkg::IDX_W-1:0] y,
                          sgnu_pkg::rule_t r);
    expected_states = {expected_states, predict_next(state, x, y, r)};
  endfunction

  function void check_state(logic [sgnu_pkg::STATE_W-1:0] actual);
    logic [sgnu_pkg::STATE_W-1:0] want;
    if (expected_states.size() == 0) begin
      $error("next_state: no item pending, actual %h", actual);
      fail_count++;
    end else begin
      want = expected_states.pop_front();
      if (actual !== want) begin
        $error("next_state mismatch: expected %h actual %h", want, actual);
        fail_count++;
      end
    end
  endfunction
endclass

module tb_top;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SW = sgnu_pkg::STATE_W;
  localparam int IW = sgnu_pkg::IDX_W;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [sgnu_pkg::RULE_W-1:0] cfg_wdata;

  sgnu_in_if  in_ch ();
  sgnu_out_if out_ch ();

  signed_graph_norm_update DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  norm_scoreboard sb = new();
  sgnu_pkg::rule_t active_rule = sgnu_pkg::RULE_L8;
  bit    tx_gaps_on  = 1'b0;
  bit    rx_stalls_on = 1'b0;
  int    rx_hold = 0;
  int    cycle_count = 0;

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // pause length: mostly short, a few long
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    else if (r < 95) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // random matrix of full field width
  function automatic logic [SW-1:0] rand_state();
    return SW'({$urandom, $urandom});
  endfunction

  // receiver back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (rx_hold > 0) begin
      out_ch.ready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if (rx_stalls_on && $urandom_range(0, 3) == 0) rx_hold = pick_pause();
    end
  end

  // watch both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) sb.check_state(out_ch.next_state);
      if (in_ch.valid && in_ch.ready)
        sb.note_item(in_ch.current_state, in_ch.actor_node, in_ch.target_node, active_rule);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // present one item and wait for it to be taken
  task automatic send_item(logic [SW-1:0] state, logic [IW-1:0] x,
                           logic [IW-1:0] y);
    int gap;
    gap = 0;
    if (tx_gaps_on && $urandom_range(0, 2) == 0) gap = pick_pause();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.current_state <= state;
    in_ch.actor_node    <= x;
    in_ch.target_node   <= y;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // stop sending and wait for every pending result
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.expected_states.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_rule(sgnu_pkg::rule_t r);
    drain_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    active_rule = r;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_directed(int count);
    logic [SW-1:0] ones;
    ones = '1;
    for (int i = 0; i < count; i++) begin
      case (i)
        0:  send_item('0, 3'd0, 3'd0);
        1:  send_item(ones, 3'd5, 3'd5);
        2:  send_item(ones, 3'd0, 3'd5);
        3:  send_item('0, 3'd5, 3'd0);
        4:  send_item(36'h555555555, 3'd2, 3'd3);
        5:  send_item(36'haaaaaaaaa, 3'd3, 3'd2);
        // actor or target out of range leaves the matrix alone
        6:  send_item(rand_state(), 3'd6, 3'd1);
        7:  send_item(rand_state(), 3'd1, 3'd7);
        8:  send_item(rand_state(), 3'd7, 3'd6);
        9:  send_item(ones, 3'd6, 3'd0);
        // diagonal bits only, actor equal to target
        10: send_item(36'h810204081, 3'd4, 3'd4);
        11: send_item(rand_state(), 3'd1, 3'd4);
        default: send_item(rand_state(), 3'd2, 3'd2);
      endcase
    end
  endtask

  function automatic logic [IW-1:0] pick_node();
    if ($urandom_range(0, 19) == 0) return IW'($urandom_range(6, 7));
    return IW'($urandom_range(0, 5));
  endfunction

  task automatic run_random(int count);
    logic [SW-1:0] state;
    for (int i = 0; i < count; i++) begin
      state = rand_state();
      case ($urandom_range(0, 3))
        0: state = state & rand_state();
        1: state = state | rand_state();
        default: ;
      endcase
      if ($urandom_range(0, 199) == 0) drain_results();
      send_item(state, pick_node(), pick_node());
    end
  endtask

  // stimulus
  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.current_state = '0;
    in_ch.actor_node    = '0;
    in_ch.target_node   = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset rule, then L4, L6 and L7, back to back with no stalls
    run_directed(12);
    write_rule(sgnu_pkg::RULE_L4);
    run_directed(4);
    write_rule(sgnu_pkg::RULE_L6);
    run_directed(4);
    write_rule(sgnu_pkg::RULE_L7);
    run_directed(4);

    // random phases across rules and idle modes
    for (int p = 0; p < 8; p++) begin
      if (p < 4) write_rule(sgnu_pkg::rule_t'(p));
      else write_rule(sgnu_pkg::rule_t'($urandom_range(0, 3)));
      tx_gaps_on   = (p % 4 == 1) || (p % 4 == 3);
      rx_stalls_on = (p % 4 == 2) || (p % 4 == 3);
      run_random(160);
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (sb.expected_states.size() != 0) begin
      $error("next_state: %0d results never arrived", sb.expected_states.size());
      sb.fail_count++;
    end
    if (sb.fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/sgnu_pkg.sv
hw/rtl/sgnu_in_if.sv
hw/rtl/sgnu_out_if.sv
hw/rtl/sgnu_rule_col.sv
hw/rtl/signed_graph_norm_update.sv
dv/tb_top.sv
